// ===== src/grid_astar_path_finder_macros.svh =====
// Assertion helpers shared by the checker
`ifndef GRID_ASTAR_PATH_FINDER_MACROS_SVH
`define GRID_ASTAR_PATH_FINDER_MACROS_SVH

// Implication checked on every clock edge outside reset
`define GAP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication outside reset
`define GAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== src/gap_pkg.sv =====
package gap_pkg;

  localparam int unsigned GridSideDefault = 8;
  localparam int unsigned CellW = 6;
  localparam int unsigned CostW = 7;
  localparam int unsigned MaxCells = 64;
  localparam int unsigned CntW = 7;

  // neighbor order
  localparam logic [2:0] DirUp    = 3'd0;
  localparam logic [2:0] DirDown  = 3'd1;
  localparam logic [2:0] DirLeft  = 3'd2;
  localparam logic [2:0] DirRight = 3'd3;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StScan,
    StPick,
    StShift,
    StNbr,
    StFind,
    StUpdate,
    StTrace,
    StEmit,
    StFail
  } state_e;

  // open list entry: cell with its cost so far and total estimate
  typedef struct packed {
    logic [CellW-1:0] node;
    logic [CostW-1:0] g;
    logic [CostW-1:0] f;
  } open_ent_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic init;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic shift_step;
    logic nbr_start;
    logic nbr_next;
    logic find_start;
    logic find_step;
    logic update;
    logic trace_start;
    logic trace_step;
    logic emit_start;
    logic emit_step;
  } gap_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic off_grid;
    logic trivial;
    logic scan_done;
    logic at_goal;
    logic open_empty;
    logic shift_done;
    logic nbr_valid;
    logic nbr_done;
    logic find_done;
    logic trace_done;
    logic trace_ok;
    logic emit_last;
  } gap_sts_t;

endpackage

// ===== src/gap_stream_if.sv =====
interface gap_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/gap_ctrl.sv =====
module gap_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_fail_o,
  output gap_pkg::gap_cmd_t cmd_o,
  input  gap_pkg::gap_sts_t sts_i
);
  import gap_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StInit;
      StInit: begin
        if (sts_i.off_grid) state_d = StFail;
        else if (sts_i.trivial) state_d = StTrace;
        else state_d = StScan;
      end
      StScan: if (sts_i.scan_done) state_d = StPick;
      StPick: begin
        if (sts_i.at_goal) state_d = StTrace;
        else state_d = StShift;
      end
      StShift: if (sts_i.shift_done) state_d = StNbr;
      StNbr: begin
        if (sts_i.nbr_done) begin
          state_d = sts_i.open_empty ? StFail : StScan;
        end else if (sts_i.nbr_valid) begin
          state_d = StFind;
        end
      end
      StFind: if (sts_i.find_done) state_d = StUpdate;
      StUpdate: state_d = StNbr;
      StTrace: begin
        if (sts_i.trace_done) state_d = sts_i.trace_ok ? StEmit : StFail;
      end
      StEmit: if (out_ready_i && sts_i.emit_last) state_d = StIdle;
      StFail: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    out_fail_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      StInit: begin
        cmd_o.init = 1'b1;
        cmd_o.trace_start = sts_i.trivial;
      end
      StScan: cmd_o.scan_step = 1'b1;
      StPick: begin
        cmd_o.pick = 1'b1;
        cmd_o.trace_start = sts_i.at_goal;
      end
      StShift: begin
        cmd_o.shift_step = 1'b1;
        cmd_o.nbr_start = sts_i.shift_done;
      end
      StNbr: begin
        cmd_o.find_start = sts_i.nbr_valid && !sts_i.nbr_done;
        cmd_o.nbr_next = !sts_i.nbr_valid && !sts_i.nbr_done;
        cmd_o.scan_start = sts_i.nbr_done;
      end
      StFind: cmd_o.find_step = 1'b1;
      StUpdate: begin
        cmd_o.update = 1'b1;
        cmd_o.nbr_next = 1'b1;
      end
      StTrace: begin
        cmd_o.trace_step = 1'b1;
        cmd_o.emit_start = sts_i.trace_done;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        cmd_o.emit_step = out_ready_i;
      end
      StFail: begin
        out_valid_o = 1'b1;
        out_fail_o = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== src/gap_datapath.sv =====
module gap_datapath #(
  parameter int unsigned GridSide = gap_pkg::GridSideDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [63:0]               wall_map_i,
  input  logic [gap_pkg::CellW-1:0] start_i,
  input  logic [gap_pkg::CellW-1:0] goal_i,
  input  gap_pkg::gap_cmd_t         cmd_i,
  output gap_pkg::gap_sts_t         sts_o,
  output logic [gap_pkg::CellW-1:0] path_cell_o
);
  import gap_pkg::*;

  localparam int unsigned Cells = GridSide * GridSide;
  localparam int unsigned RcW = 3;

  // open list entries carry g and f, so per-cell cost tables are not needed
  open_ent_t        open_mem [MaxCells];
  logic [CellW-1:0] pred_mem [MaxCells];
  logic [CellW-1:0] pbuf_mem [MaxCells];

  open_ent_t        ord_q;
  logic [CellW-1:0] prd_q;
  logic [CellW-1:0] pcell_q;

  logic [CntW-1:0]  cnt_q;
  logic [63:0]      closed_q;
  logic [CellW-1:0] start_q, goal_q, cur_q, nb_q, bcell_q, tc_q;
  logic [CntW-1:0]  rd_q, sidx_q, best_q, pos_q, plen_q, ecnt_q, ecnt_d;
  logic             svld_q, hit_q, tph_q;
  logic [CostW-1:0] bestf_q, bg_q, gcur_q, hitg_q;
  logic [2:0]       dir_q;

  logic [RcW-1:0]   cur_r, cur_c;
  logic             cand_ok;
  logic [CellW-1:0] cand_nb;
  logic [CostW-1:0] tent, tent_f, start_h;
  logic             pipe_done, at_goal, trace_done;
  logic             owe, pwe, pb_we;
  logic [CellW-1:0] owa, pb_wa, pb_wd;
  open_ent_t        owr;

  // row by compares against constant multiples of the side
  function automatic logic [RcW-1:0] row_of(logic [CellW-1:0] a);
    logic [RcW-1:0] r;
    r = '0;
    for (int i = 1; i < (1 << RcW); i++) begin
      if (32'(a) >= 32'(i) * GridSide) r = RcW'(i);
    end
    return r;
  endfunction

  function automatic logic [RcW-1:0] col_of(logic [CellW-1:0] a);
    logic [CellW-1:0] base;
    base = CellW'(32'(row_of(a)) * GridSide);
    return RcW'(a - base);
  endfunction

  function automatic logic [CostW-1:0] manh(logic [CellW-1:0] a, logic [CellW-1:0] b);
    logic [RcW-1:0] ra, ca, rb, cb, dr, dc;
    ra = row_of(a);
    ca = col_of(a);
    rb = row_of(b);
    cb = col_of(b);
    dr = (ra > rb) ? ra - rb : rb - ra;
    dc = (ca > cb) ? ca - cb : cb - ca;
    return CostW'(dr) + CostW'(dc);
  endfunction

  assign cur_r = row_of(cur_q);
  assign cur_c = col_of(cur_q);
  assign tent = gcur_q + CostW'(1);
  assign tent_f = tent + manh(nb_q, goal_q);
  assign start_h = manh(start_q, goal_q);
  assign pipe_done = rd_q >= cnt_q && !svld_q;
  assign at_goal = bcell_q == goal_q;
  assign trace_done = tc_q == start_q || plen_q >= CntW'(Cells);

  always_comb begin
    cand_ok = 1'b0;
    cand_nb = cur_q;
    case (dir_q)
      DirUp: begin
        cand_ok = cur_r != '0;
        cand_nb = cur_q - CellW'(GridSide);
      end
      DirDown: begin
        cand_ok = 32'(cur_r) + 1 < GridSide;
        cand_nb = cur_q + CellW'(GridSide);
      end
      DirLeft: begin
        cand_ok = cur_c != '0;
        cand_nb = cur_q - CellW'(1);
      end
      DirRight: begin
        cand_ok = 32'(cur_c) + 1 < GridSide;
        cand_nb = cur_q + CellW'(1);
      end
      default: ;
    endcase
    if (wall_map_i[cand_nb] || closed_q[cand_nb]) cand_ok = 1'b0;
  end

  // open list write port
  always_comb begin
    owe = 1'b0;
    owa = '0;
    owr = '0;
    if (cmd_i.init) begin
      owe = 1'b1;
      owr.node = start_q;
      owr.f = start_h;
    end else if (cmd_i.shift_step && svld_q) begin
      owe = 1'b1;
      owa = sidx_q[CellW-1:0] - CellW'(1);
      owr = ord_q;
    end else if (cmd_i.update && !hit_q && cnt_q < CntW'(MaxCells)) begin
      owe = 1'b1;
      owa = cnt_q[CellW-1:0];
      owr.node = nb_q;
      owr.g = tent;
      owr.f = tent_f;
    end else if (cmd_i.update && hit_q && tent < hitg_q) begin
      owe = 1'b1;
      owa = pos_q[CellW-1:0];
      owr.node = nb_q;
      owr.g = tent;
      owr.f = tent_f;
    end
  end

  assign pwe = cmd_i.update && (hit_q ? tent < hitg_q : cnt_q < CntW'(MaxCells));

  assign pb_we = cmd_i.trace_start || (cmd_i.trace_step && !trace_done && tph_q);
  assign pb_wa = cmd_i.trace_start ? '0 : plen_q[CellW-1:0];
  assign pb_wd = cmd_i.trace_start ? goal_q : prd_q;

  always_comb begin
    ecnt_d = ecnt_q;
    if (cmd_i.emit_start) ecnt_d = plen_q - CntW'(1);
    else if (cmd_i.emit_step) ecnt_d = ecnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (owe) open_mem[owa] <= owr;
    ord_q <= open_mem[rd_q[CellW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pwe) pred_mem[nb_q] <= cur_q;
    prd_q <= pred_mem[tc_q];
  end

  // pcell_q always holds the buffer entry at ecnt_q
  always_ff @(posedge clk_i) begin
    if (pb_we) pbuf_mem[pb_wa] <= pb_wd;
    pcell_q <= pbuf_mem[ecnt_d[CellW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      closed_q <= '0;
    end else begin
      if (cmd_i.init) begin
        cnt_q <= CntW'(1);
        closed_q <= '0;
      end else if (cmd_i.pick && !at_goal) begin
        closed_q[bcell_q] <= 1'b1;
      end else if (cmd_i.shift_step && pipe_done) begin
        cnt_q <= cnt_q - CntW'(1);
      end else if (cmd_i.update && !hit_q && cnt_q < CntW'(MaxCells)) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      start_q <= start_i;
      goal_q <= goal_i;
    end
    // one read pipeline over the open list, shared by scan, shift and find
    if (cmd_i.init || cmd_i.scan_start || cmd_i.find_start) begin
      rd_q <= '0;
      svld_q <= 1'b0;
    end else if (cmd_i.pick) begin
      rd_q <= best_q + CntW'(1);
      svld_q <= 1'b0;
    end else if (cmd_i.scan_step || cmd_i.shift_step || cmd_i.find_step) begin
      if (rd_q < cnt_q) begin
        rd_q <= rd_q + CntW'(1);
        sidx_q <= rd_q;
        svld_q <= 1'b1;
      end else begin
        svld_q <= 1'b0;
      end
    end
    // earliest entry with the lowest f wins
    if (cmd_i.scan_step && svld_q && (sidx_q == '0 || ord_q.f < bestf_q)) begin
      best_q <= sidx_q;
      bestf_q <= ord_q.f;
      bcell_q <= ord_q.node;
      bg_q <= ord_q.g;
    end
    if (cmd_i.pick) begin
      cur_q <= bcell_q;
      gcur_q <= bg_q;
    end
    if (cmd_i.nbr_start) dir_q <= DirUp;
    else if (cmd_i.nbr_next) dir_q <= dir_q + 3'd1;
    if (cmd_i.find_start) begin
      nb_q <= cand_nb;
      hit_q <= 1'b0;
    end else if (cmd_i.find_step && svld_q && !hit_q && ord_q.node == nb_q) begin
      hit_q <= 1'b1;
      pos_q <= sidx_q;
      hitg_q <= ord_q.g;
    end
    // per path cell: read pred, then take it
    if (cmd_i.trace_start) begin
      tc_q <= goal_q;
      plen_q <= CntW'(1);
      tph_q <= 1'b0;
    end else if (cmd_i.trace_step && !trace_done) begin
      tph_q <= !tph_q;
      if (tph_q) begin
        tc_q <= prd_q;
        plen_q <= plen_q + CntW'(1);
      end
    end
    ecnt_q <= ecnt_d;
  end

  always_comb begin
    sts_o = '0;
    sts_o.off_grid = 32'(start_q) >= Cells || 32'(goal_q) >= Cells;
    sts_o.trivial = start_q == goal_q;
    sts_o.scan_done = pipe_done;
    sts_o.at_goal = at_goal;
    sts_o.open_empty = cnt_q == '0;
    sts_o.shift_done = pipe_done;
    sts_o.nbr_done = dir_q[2];
    sts_o.nbr_valid = cand_ok;
    sts_o.find_done = hit_q || pipe_done;
    sts_o.trace_done = trace_done;
    sts_o.trace_ok = tc_q == start_q;
    sts_o.emit_last = ecnt_q == '0;
  end

  assign path_cell_o = pcell_q;
endmodule

// ===== src/grid_astar_path_finder.sv =====
// A* path search on a GRID_SIDE x GRID_SIDE 4-connected grid (walls from wall_map).
// One request (start, goal) yields the path start..goal, one cell per result item,
// last on the final one; an unreachable goal, or a start or goal off the grid, yields
// a single item with found clear. One request at a time. The open list and the
// per-cell tables sit in memories with registered reads. An expansion scans the open
// list for the lowest f, picks that entry, closes the gap it leaves, and per neighbor
// searches the open list and then does the update. There are up to 64 expansions of up
// to 64 open entries each. The readout walks the predecessor chain, then sends one item
// per cycle while the receiver is ready. wall_map must be written only while idle; the
// block itself does not enforce this.
module grid_astar_path_finder #(
  parameter int unsigned GRID_SIDE = gap_pkg::GridSideDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [63:0] cfg_wdata_i,
  gap_stream_if.sink   req,
  gap_stream_if.source rsp
);
  import gap_pkg::*;

  logic [63:0] wall_q;
  gap_cmd_t cmd;
  gap_sts_t sts;
  logic fail;
  logic [CellW-1:0] pcell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q <= '0;
    end else if (cfg_we_i) begin
      wall_q <= cfg_wdata_i;
    end
  end

  gap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .out_fail_o (fail),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gap_datapath #(.GridSide(GRID_SIDE)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wall_map_i (wall_q),
    .start_i    (req.data.start_cell),
    .goal_i     (req.data.goal_cell),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .path_cell_o(pcell)
  );

  assign rsp.data.path_cell = fail ? '0 : pcell;
  assign rsp.data.found = !fail;
  assign rsp.data.last = fail || sts.emit_last;
endmodule

// ===== src/gap_checker.sv =====
module gap_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic found,
  input logic last
);
  `include "grid_astar_path_finder_macros.svh"

  `GAP_ASSERT_IMPL(a_fail_last, clk_i, rst_ni, out_valid && !found, last)
  `GAP_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, out_valid, !in_ready)
  `GAP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `GAP_ASSERT_NEXT(a_take_busy, clk_i, rst_ni, in_valid && in_ready, !in_ready)
endmodule

bind grid_astar_path_finder gap_checker u_gap_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (req.valid),
  .in_ready (req.ready),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .found    (rsp.data.found),
  .last     (rsp.data.last)
);
